// ----- src/sqr_pkg.sv -----
`default_nettype none
package sqr_pkg;
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NEG = 2'd1;
  localparam logic [1:0] ST_AZ  = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;
  localparam int ROOT_WIDTH = 32;
endpackage
`default_nettype wire

// ----- src/sqr_if.sv -----
`default_nettype none
interface sqr_in_if #(parameter int CW = 16);
  logic valid;
  logic ready;
  logic signed [CW-1:0] coef_a;
  logic signed [CW-1:0] coef_b;
  logic signed [CW-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface sqr_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] root_far;
  logic signed [31:0] root_near;
  logic [1:0] status;
  modport source (output valid, root_far, root_near, status, input ready);
  modport sink (input valid, root_far, root_near, status, output ready);
endinterface
`default_nettype wire

// ----- src/stable_quadratic_roots.sv -----
// Quadratic root solver, numerically stable form.
// The in_ channel takes coefficients a, b, c (signed, common scale); the out_
// channel returns root_far = t/a and root_near = c/t in signed fixed point
// with ROOT_FRAC_BITS fraction bits, plus a two-bit status (ok, negative
// discriminant, a zero, saturated). Items flow through a linear pipeline of
// 2*COEF_WIDTH + ROOT_FRAC_BITS + 6 register stages (54 by default): one for
// the magnitudes and q, one per result bit of the square root, one for the
// fix-up and |b| + S, one divider input stage, one per quotient bit of the two
// dividers (which run side by side), and the output register. Throughput is
// one item per cycle. The pipeline advances only when the last stage is
// empty or its item is taken, so when the receiver stalls the whole
// pipeline holds and in_ready falls; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module stable_quadratic_roots import sqr_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int ROOT_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sqr_in_if.sink    in_ch,
  sqr_out_if.source out_ch
);
  localparam int CW = COEF_WIDTH;
  localparam int FB = ROOT_FRAC_BITS;
  localparam int QW = 2*CW;            // width of q
  localparam int SH = CW;              // isqrt steps (sqrt q has CW bits)
  localparam int SW = CW + 1;          // width of S
  localparam int MW = CW + 2;          // width of M
  localparam int N1W = MW + FB;        // dividend widths
  localparam int N2W = CW + FB + 1;
  localparam int DV = (N1W > N2W) ? N1W : N2W;  // divider steps
  localparam int RW = QW + 2;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 0: magnitudes and q
  logic [CW-1:0] ma, mb, mc;
  logic na, nb, nc;
  logic [2*CW-1:0] sq, p;
  logic [QW:0] q0;
  logic neg0;
  always_comb begin
    na = in_ch.coef_a[CW-1];
    nb = in_ch.coef_b[CW-1];
    nc = in_ch.coef_c[CW-1];
    ma = na ? CW'(-in_ch.coef_a) : in_ch.coef_a;
    mb = nb ? CW'(-in_ch.coef_b) : in_ch.coef_b;
    mc = nc ? CW'(-in_ch.coef_c) : in_ch.coef_c;
    sq = mb * mb;
    p = ma * mc;
    neg0 = 1'b0;
    if (p != '0 && na == nc) begin
      neg0 = p > (sq >> 2);
      q0 = (QW+1)'(sq >> 2) - (QW+1)'(p);
    end else begin
      q0 = (QW+1)'(sq >> 2) + (QW+1)'(p);
    end
  end

  typedef struct packed {
    logic [CW-1:0] ma, mb, mc;
    logic na, nb, nc;
    logic rb;
    logic [1:0] st;
  } hdr_t;

  hdr_t h0;
  always_comb begin
    h0.ma = ma; h0.mb = mb; h0.mc = mc;
    h0.na = na; h0.nb = nb; h0.nc = nc;
    h0.rb = sq[1:0] != 2'b00;
    h0.st = (ma == '0) ? ST_AZ : (neg0 ? ST_NEG : ST_OK);
  end

  // square root pipeline, one result bit per stage (restoring)
  logic [SH:0] sv_r;
  hdr_t sh_r [SH+1];
  logic [RW-1:0] srem_r [SH+1];
  logic [QW-1:0] sval_r [SH+1];
  logic [CW-1:0] sroot_r [SH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= '0;
    else if (adv) sv_r <= {sv_r[SH-1:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_r[0] <= h0;
      srem_r[0] <= '0;
      sval_r[0] <= q0[QW-1:0];
      sroot_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < SH; i++) begin : g_sqrt
    logic [RW-1:0] rem_t, trial;
    always_comb begin
      rem_t = {srem_r[i][RW-3:0], sval_r[i][QW-1 -: 2]};
      trial = RW'({sroot_r[i], 2'b01});
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sh_r[i+1] <= sh_r[i];
        sval_r[i+1] <= sval_r[i] << 2;
        if (rem_t >= trial) begin
          srem_r[i+1] <= rem_t - trial;
          sroot_r[i+1] <= {sroot_r[i][CW-2:0], 1'b1};
        end else begin
          srem_r[i+1] <= rem_t;
          sroot_r[i+1] <= {sroot_r[i][CW-2:0], 1'b0};
        end
      end
    end
  end

  // fix-up stage: S = floor(sqrt(4q+rb)), M = |b| + S
  logic [SW-1:0] s_fix;
  logic [RW-1:0] rem_l;
  logic [RW-1:0] root_l;
  always_comb begin
    rem_l = srem_r[SH];
    root_l = RW'(sroot_r[SH]);
    if (rem_l > root_l || (rem_l == root_l && sh_r[SH].rb))
      s_fix = {sroot_r[SH], 1'b1};
    else
      s_fix = {sroot_r[SH], 1'b0};
  end

  logic mv_r;
  hdr_t mh_r;
  logic [MW-1:0] m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else if (adv) mv_r <= sv_r[SH];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mh_r <= sh_r[SH];
      m_r <= MW'(sh_r[SH].mb) + MW'(s_fix);
    end
  end

  // two restoring dividers side by side, DV quotient bits each
  localparam int D1W = CW + 1;  // 2|a|
  localparam int D2W = MW;
  localparam int R1W = D1W + 1;
  localparam int R2W = D2W + 1;

  logic [DV:0] dv_r;
  hdr_t dh_r [DV+1];
  logic [MW-1:0] dm_r [DV+1];
  logic [DV-1:0] n1_r [DV+1], n2_r [DV+1];
  logic [DV-1:0] q1_r [DV+1], q2_r [DV+1];
  logic [R1W-1:0] r1_r [DV+1];
  logic [R2W-1:0] r2_r [DV+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else if (adv) dv_r <= {dv_r[DV-1:0], mv_r};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dh_r[0] <= mh_r;
      dm_r[0] <= m_r;
      n1_r[0] <= DV'({m_r, {FB{1'b0}}});
      n2_r[0] <= DV'({mh_r.mc, {(FB+1){1'b0}}});
      q1_r[0] <= '0;
      q2_r[0] <= '0;
      r1_r[0] <= '0;
      r2_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < DV; i++) begin : g_div
    logic [R1W-1:0] t1, d1;
    logic [R2W-1:0] t2, d2;
    always_comb begin
      t1 = {r1_r[i][R1W-2:0], n1_r[i][DV-1]};
      t2 = {r2_r[i][R2W-2:0], n2_r[i][DV-1]};
      d1 = R1W'({dh_r[i].ma, 1'b0});
      d2 = R2W'(dm_r[i]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dh_r[i+1] <= dh_r[i];
        dm_r[i+1] <= dm_r[i];
        n1_r[i+1] <= n1_r[i] << 1;
        n2_r[i+1] <= n2_r[i] << 1;
        if (d1 != '0 && t1 >= d1) begin
          r1_r[i+1] <= t1 - d1;
          q1_r[i+1] <= {q1_r[i][DV-2:0], 1'b1};
        end else begin
          r1_r[i+1] <= t1;
          q1_r[i+1] <= {q1_r[i][DV-2:0], 1'b0};
        end
        if (d2 != '0 && t2 >= d2) begin
          r2_r[i+1] <= t2 - d2;
          q2_r[i+1] <= {q2_r[i][DV-2:0], 1'b1};
        end else begin
          r2_r[i+1] <= t2;
          q2_r[i+1] <= {q2_r[i][DV-2:0], 1'b0};
        end
      end
    end
  end

  // pack and saturate
  localparam int PW = (DV > 33) ? DV : 33;
  logic [PW-1:0] mag1, mag2;
  logic [31:0] r1p, r2p;
  logic sat1, sat2, nt;
  hdr_t hl;

  function automatic logic [31:0] pack(input logic [PW-1:0] mag, input logic ng,
                                       output logic sat);
    logic [PW-1:0] half;
    logic [PW-1:0] m;
    half = PW'(1) << 31;
    m = mag;
    sat = 1'b0;
    if (ng) begin
      if (m > half) begin sat = 1'b1; m = half; end
      return 32'(-m);
    end
    if (m > half - PW'(1)) begin sat = 1'b1; m = half - PW'(1); end
    return m[31:0];
  endfunction

  always_comb begin
    hl = dh_r[DV];
    nt = !hl.nb;
    mag1 = PW'(q1_r[DV]);
    mag2 = (dm_r[DV] == '0) ? '0 : PW'(q2_r[DV]);
    r1p = pack(mag1, nt != hl.na, sat1);
    r2p = pack(mag2, hl.nc != nt, sat2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= dv_r[DV];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (hl.st != ST_OK) begin
        out_ch.root_far <= '0;
        out_ch.root_near <= '0;
        out_ch.status <= hl.st;
      end else begin
        out_ch.root_far <= r1p;
        out_ch.root_near <= r2p;
        out_ch.status <= (sat1 || sat2) ? ST_SAT : ST_OK;
      end
    end
  end
endmodule
`default_nettype wire
